// ===== hdl/fgn_pkg.sv =====
// shared types, constants and helper functions for the fractal gradient noise block
`default_nettype none
package fgn_pkg;
   localparam int TABLE_SIZE  = 256;
   localparam int TBL_AW      = $clog2(TABLE_SIZE);
   localparam int BYTE_W      = 8;
   localparam int MAX_OCTAVES = 8;
   localparam int OCT_W       = 4;
   localparam int COORD_W     = 24;
   localparam int FRAC_W      = 16;
   localparam int NOISE_W     = 18;
   localparam int HEIGHT_W    = 8;
   localparam int GRAD_W      = 19;
   localparam int OCT_NOISE_W = 20;
   localparam int ACC_W       = OCT_NOISE_W + MAX_OCTAVES;
   localparam int MAG_W       = ACC_W - 1;
   localparam int DIV_W       = MAX_OCTAVES;
   localparam int RECIP_W     = 32;
   localparam int REQ_DATA_W  = 64;
   localparam int RSP_DATA_W  = 32;

   localparam int INNER_BIAS  = 10 * 65536;
   localparam int ONE_Q16     = 65536;
   localparam int NOISE_MAX   = 131071;
   localparam int NOISE_MIN_MAG = 131072;
   localparam int HEIGHT_MAX  = 255;

   // pipeline stage numbers
   localparam int ST_IN    = 1;
   localparam int ST_A     = 2;
   localparam int ST_B     = 3;
   localparam int ST_GRAD  = 4;
   localparam int ST_MUL1  = 5;
   localparam int ST_LERP1 = 6;
   localparam int ST_MUL2  = 7;
   localparam int ST_NOISE = 8;
   localparam int ST_TERM  = 9;
   localparam int ST_SUM   = 10;
   localparam int ST_MAG   = 11;
   localparam int ST_RECIP = 12;
   localparam int ST_BACK  = 13;
   localparam int ST_QUOT  = 14;
   localparam int ST_SAT   = 15;
   localparam int ST_OUT   = 16;
   localparam int LANE_FIRST = ST_A;
   localparam int LANE_LAST  = ST_NOISE;
   localparam int NORM_FIRST = ST_TERM;
   localparam int NUM_STAGES = ST_OUT;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   localparam logic [1:0] GRAD_XPY = 2'd0;
   localparam logic [1:0] GRAD_YMX = 2'd1;
   localparam logic [1:0] GRAD_XMY = 2'd2;
   localparam logic [1:0] GRAD_NEG = 2'd3;

   typedef struct packed {
      logic              we;
      logic [TBL_AW-1:0] addr;
      logic [BYTE_W-1:0] data;
   } tbl_wr_type;

   typedef logic signed [GRAD_W-1:0] grad_type;

   function automatic grad_type grad(input logic [1:0] h,
                                     input logic signed [FRAC_W+1:0] gx,
                                     input logic signed [FRAC_W+1:0] gy);
      grad_type sx, sy, g;
      sx = GRAD_W'(gx);
      sy = GRAD_W'(gy);
      unique case (h)
         GRAD_XPY: g = sx + sy;
         GRAD_YMX: g = sy - sx;
         GRAD_XMY: g = sx - sy;
         default:  g = -sx - sy;
      endcase
      return g;
   endfunction

   function automatic logic [OCT_W-1:0] clamp_oct(input logic [OCT_W-1:0] c);
      logic [OCT_W-1:0] r;
      if (c == '0) r = OCT_W'(1);
      else if (c > OCT_W'(MAX_OCTAVES)) r = OCT_W'(MAX_OCTAVES);
      else r = c;
      return r;
   endfunction

   // total weight 2^n - 1
   function automatic logic [DIV_W-1:0] divisor(input logic [OCT_W-1:0] n);
      logic [DIV_W:0] one;
      one = (DIV_W+1)'(1) << n;
      return DIV_W'(one - (DIV_W+1)'(1));
   endfunction

   // floor(2^32 / (2^n - 1)), all ones for a single octave
   function automatic logic [RECIP_W-1:0] recip(input logic [OCT_W-1:0] n);
      logic [RECIP_W-1:0] r;
      unique case (n)
         4'd2:    r = 32'h5555_5555;
         4'd3:    r = 32'h2492_4924;
         4'd4:    r = 32'h1111_1111;
         4'd5:    r = 32'h0842_1084;
         4'd6:    r = 32'h0410_4104;
         4'd7:    r = 32'h0204_0810;
         4'd8:    r = 32'h0101_0101;
         default: r = 32'hFFFF_FFFF;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

// ===== hdl/fgn_lane.sv =====
// one octave lane: table lookups, fade, gradients and the three interpolations
`default_nettype none
module fgn_lane #(
   parameter int unsigned OCT = 0
) (
   input  logic                                              clock,
   input  logic [fgn_pkg::LANE_LAST:fgn_pkg::LANE_FIRST]     stage_en,
   input  fgn_pkg::tbl_wr_type                               wr_a,
   input  fgn_pkg::tbl_wr_type                               wr_b,
   input  logic [fgn_pkg::COORD_W-1:0]                       x_coord,
   input  logic [fgn_pkg::COORD_W-1:0]                       y_coord,
   output logic signed [fgn_pkg::OCT_NOISE_W-1:0]            noise
);
   import fgn_pkg::*;

   localparam int SHIFT_W = COORD_W + MAX_OCTAVES;

   function automatic logic [19:0] fade_inner(input logic [FRAC_W-1:0] t2,
                                              input logic [FRAC_W-1:0] t);
      logic [21:0] pos, negp;
      pos  = 22'({t2, 2'b0}) + 22'({t2, 1'b0}) + 22'(INNER_BIAS);
      negp = 22'({t, 4'b0}) - 22'(t);
      return (pos > negp) ? 20'(pos - negp) : '0;
   endfunction

   logic [BYTE_W-1:0] mem_a  [TABLE_SIZE];
   logic [BYTE_W-1:0] mem_b0 [TABLE_SIZE];
   logic [BYTE_W-1:0] mem_b1 [TABLE_SIZE];

   logic [SHIFT_W-1:0] cx, cy;
   logic [TBL_AW-1:0]  ix, ix1;
   logic [FRAC_W-1:0]  fx, fy;
   logic [2*FRAC_W-1:0] sqx, sqy;

   assign cx  = SHIFT_W'(x_coord) << OCT;
   assign cy  = SHIFT_W'(y_coord) << OCT;
   assign ix  = cx[FRAC_W +: TBL_AW];
   assign ix1 = ix + TBL_AW'(1);
   assign fx  = cx[FRAC_W-1:0];
   assign fy  = cy[FRAC_W-1:0];
   assign sqx = {16'b0, fx} * {16'b0, fx};
   assign sqy = {16'b0, fy} * {16'b0, fy};

   // stage a: first hash lookups, fade squares
   logic [BYTE_W-1:0] pa_ff, pb_ff;
   logic [TBL_AW-1:0] iy_ff;
   logic [FRAC_W-1:0] fx2_ff, fy2_ff, t2x_ff, t2y_ff;

   always_ff @(posedge clock) begin
      if (wr_a.we) mem_a[wr_a.addr] <= wr_a.data;
      if (stage_en[ST_A]) begin
         pa_ff  <= mem_a[ix];
         pb_ff  <= mem_a[ix1];
         iy_ff  <= cy[FRAC_W +: TBL_AW];
         fx2_ff <= fx;
         fy2_ff <= fy;
         t2x_ff <= sqx[2*FRAC_W-1:FRAC_W];
         t2y_ff <= sqy[2*FRAC_W-1:FRAC_W];
      end
   end

   // stage b: corner hashes, fade cubes and inner polynomial
   logic [TBL_AW-1:0] ha, ha1, hb, hb1;
   logic [2*FRAC_W-1:0] cux, cuy;
   logic [BYTE_W-1:0] aa_ff, ab_ff, ba_ff, bb_ff;
   logic [FRAC_W-1:0] fx3_ff, fy3_ff, t3x_ff, t3y_ff;
   logic [19:0]       inx_ff, iny_ff;

   assign ha  = TBL_AW'(pa_ff) + iy_ff;
   assign hb  = TBL_AW'(pb_ff) + iy_ff;
   assign ha1 = ha + TBL_AW'(1);
   assign hb1 = hb + TBL_AW'(1);
   assign cux = {16'b0, t2x_ff} * {16'b0, fx2_ff};
   assign cuy = {16'b0, t2y_ff} * {16'b0, fy2_ff};

   always_ff @(posedge clock) begin
      if (wr_b.we) begin
         mem_b0[wr_b.addr] <= wr_b.data;
         mem_b1[wr_b.addr] <= wr_b.data;
      end
      if (stage_en[ST_B]) begin
         aa_ff  <= mem_b0[ha];
         ab_ff  <= mem_b0[ha1];
         ba_ff  <= mem_b1[hb];
         bb_ff  <= mem_b1[hb1];
         fx3_ff <= fx2_ff;
         fy3_ff <= fy2_ff;
         t3x_ff <= cux[2*FRAC_W-1:FRAC_W];
         t3y_ff <= cuy[2*FRAC_W-1:FRAC_W];
         inx_ff <= fade_inner(t2x_ff, fx2_ff);
         iny_ff <= fade_inner(t2y_ff, fy2_ff);
      end
   end

   // stage grad: corner gradients and fade weights
   logic signed [FRAC_W+1:0] x0, x1, y0, y1;
   logic [35:0] ux_p, vy_p;
   grad_type gaa_ff, gab_ff, gba_ff, gbb_ff;
   logic [FRAC_W:0] ux_ff, vy_ff;

   assign x0   = {2'b00, fx3_ff};
   assign x1   = {2'b11, fx3_ff};
   assign y0   = {2'b00, fy3_ff};
   assign y1   = {2'b11, fy3_ff};
   assign ux_p = {20'b0, t3x_ff} * {16'b0, inx_ff};
   assign vy_p = {20'b0, t3y_ff} * {16'b0, iny_ff};

   always_ff @(posedge clock) begin
      if (stage_en[ST_GRAD]) begin
         gaa_ff <= grad(aa_ff[1:0], x0, y0);
         gba_ff <= grad(ba_ff[1:0], x1, y0);
         gab_ff <= grad(ab_ff[1:0], x0, y1);
         gbb_ff <= grad(bb_ff[1:0], x1, y1);
         ux_ff  <= ux_p[FRAC_W +: FRAC_W+1];
         vy_ff  <= vy_p[FRAC_W +: FRAC_W+1];
      end
   end

   // first interpolation, product then add
   logic signed [OCT_NOISE_W-1:0] d1, d2;
   logic signed [37:0] p1_in, p2_in, p1_ff, p2_ff;
   grad_type gaa5_ff, gab5_ff;
   logic [FRAC_W:0] vy5_ff, vy6_ff;

   assign d1    = OCT_NOISE_W'(gba_ff) - OCT_NOISE_W'(gaa_ff);
   assign d2    = OCT_NOISE_W'(gbb_ff) - OCT_NOISE_W'(gab_ff);
   assign p1_in = $signed({1'b0, ux_ff}) * d1;
   assign p2_in = $signed({1'b0, ux_ff}) * d2;

   always_ff @(posedge clock) begin
      if (stage_en[ST_MUL1]) begin
         p1_ff   <= p1_in;
         p2_ff   <= p2_in;
         gaa5_ff <= gaa_ff;
         gab5_ff <= gab_ff;
         vy5_ff  <= vy_ff;
      end
   end

   logic signed [OCT_NOISE_W-1:0] l1_ff, l2_ff;
   always_ff @(posedge clock) begin
      if (stage_en[ST_LERP1]) begin
         l1_ff  <= OCT_NOISE_W'(gaa5_ff) + OCT_NOISE_W'(p1_ff >>> FRAC_W);
         l2_ff  <= OCT_NOISE_W'(gab5_ff) + OCT_NOISE_W'(p2_ff >>> FRAC_W);
         vy6_ff <= vy5_ff;
      end
   end

   // second interpolation along y
   logic signed [OCT_NOISE_W:0]   d3;
   logic signed [38:0]            p3_in, p3_ff;
   logic signed [OCT_NOISE_W-1:0] l17_ff, noise_ff;

   assign d3    = (OCT_NOISE_W+1)'(l2_ff) - (OCT_NOISE_W+1)'(l1_ff);
   assign p3_in = $signed({1'b0, vy6_ff}) * d3;

   always_ff @(posedge clock) begin
      if (stage_en[ST_MUL2]) begin
         p3_ff  <= p3_in;
         l17_ff <= l1_ff;
      end
      if (stage_en[ST_NOISE]) begin
         noise_ff <= l17_ff + OCT_NOISE_W'(p3_ff >>> FRAC_W);
      end
   end

   assign noise = noise_ff;
endmodule
`default_nettype wire

// ===== hdl/fgn_norm.sv =====
// weighted octave sum, division by total weight, saturation and height mapping
`default_nettype none
module fgn_norm (
   input  logic                                          clock,
   input  logic [fgn_pkg::NUM_STAGES:fgn_pkg::NORM_FIRST] stage_en,
   input  logic signed [fgn_pkg::OCT_NOISE_W-1:0]        oct_noise [fgn_pkg::MAX_OCTAVES],
   input  logic [fgn_pkg::OCT_W-1:0]                     oct_count,
   input  logic                                          is_eval,
   output logic signed [fgn_pkg::NOISE_W-1:0]            noise_value,
   output logic [fgn_pkg::HEIGHT_W-1:0]                  height_byte,
   output logic                                          is_eval_out
);
   import fgn_pkg::*;

   // weighted terms
   logic signed [ACC_W-1:0] term_in [MAX_OCTAVES];
   logic signed [ACC_W-1:0] term_ff [MAX_OCTAVES];
   logic [OCT_W-1:0] oct9_ff, oct10_ff;
   logic ev9_ff, ev10_ff, ev11_ff, ev12_ff, ev13_ff, ev14_ff, ev15_ff;

   always_comb begin
      for (int k = 0; k < MAX_OCTAVES; k++) begin
         if (OCT_W'(k) < oct_count)
            term_in[k] = ACC_W'(oct_noise[k]) <<< (oct_count - OCT_W'(k + 1));
         else
            term_in[k] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_TERM]) begin
         term_ff <= term_in;
         oct9_ff <= oct_count;
         ev9_ff  <= is_eval;
      end
   end

   logic signed [ACC_W-1:0] acc_in, acc_ff;
   always_comb begin
      acc_in = '0;
      for (int k = 0; k < MAX_OCTAVES; k++) acc_in = acc_in + term_ff[k];
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_SUM]) begin
         acc_ff   <= acc_in;
         oct10_ff <= oct9_ff;
         ev10_ff  <= ev9_ff;
      end
   end

   // floor division of a negative sum: -((-a + d - 1) / d), and -a + d - 1 = ~a + d
   logic [DIV_W-1:0]   d_in;
   logic [ACC_W-1:0]   mag_neg;
   logic [MAG_W-1:0]   mag11_ff, mag12_ff, mag13_ff;
   logic [RECIP_W-1:0] recip_ff;
   logic [DIV_W-1:0]   d11_ff, d12_ff, d13_ff;
   logic               neg11_ff, neg12_ff, neg13_ff, neg14_ff;

   assign d_in    = divisor(oct10_ff);
   assign mag_neg = ~acc_ff + ACC_W'(d_in);

   always_ff @(posedge clock) begin
      if (stage_en[ST_MAG]) begin
         mag11_ff <= acc_ff[ACC_W-1] ? MAG_W'(mag_neg) : MAG_W'(acc_ff);
         recip_ff <= recip(oct10_ff);
         d11_ff   <= d_in;
         neg11_ff <= acc_ff[ACC_W-1];
         ev11_ff  <= ev10_ff;
      end
   end

   // quotient estimate, low by at most one
   logic [MAG_W+RECIP_W-1:0] qp;
   logic [MAG_W-1:0]         qest12_ff, qest13_ff, qd13_ff;
   assign qp = {{RECIP_W{1'b0}}, mag11_ff} * {{MAG_W{1'b0}}, recip_ff};

   always_ff @(posedge clock) begin
      if (stage_en[ST_RECIP]) begin
         qest12_ff <= qp[RECIP_W +: MAG_W];
         mag12_ff  <= mag11_ff;
         d12_ff    <= d11_ff;
         neg12_ff  <= neg11_ff;
         ev12_ff   <= ev11_ff;
      end
   end

   logic [MAG_W+DIV_W-1:0] qd;
   assign qd = {{DIV_W{1'b0}}, qest12_ff} * {{MAG_W{1'b0}}, d12_ff};

   always_ff @(posedge clock) begin
      if (stage_en[ST_BACK]) begin
         qd13_ff   <= MAG_W'(qd);
         qest13_ff <= qest12_ff;
         mag13_ff  <= mag12_ff;
         d13_ff    <= d12_ff;
         neg13_ff  <= neg12_ff;
         ev13_ff   <= ev12_ff;
      end
   end

   logic [MAG_W-1:0] rem, q14_ff;
   assign rem = mag13_ff - qd13_ff;

   always_ff @(posedge clock) begin
      if (stage_en[ST_QUOT]) begin
         q14_ff   <= (rem >= MAG_W'(d13_ff)) ? qest13_ff + MAG_W'(1) : qest13_ff;
         neg14_ff <= neg13_ff;
         ev14_ff  <= ev13_ff;
      end
   end

   // saturate into q2.16
   logic signed [NOISE_W-1:0] res_in, res15_ff;
   always_comb begin
      if (neg14_ff) begin
         if (q14_ff > MAG_W'(NOISE_MIN_MAG)) res_in = NOISE_W'(-NOISE_MIN_MAG);
         else res_in = NOISE_W'(-q14_ff);
      end else begin
         if (q14_ff > MAG_W'(NOISE_MAX)) res_in = NOISE_W'(NOISE_MAX);
         else res_in = NOISE_W'(q14_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_SAT]) begin
         res15_ff <= res_in;
         ev15_ff  <= ev14_ff;
      end
   end

   // height: floor((noise + 1.0) * 255 / 2)
   logic signed [NOISE_W:0] hv;
   logic [26:0]             hp;
   logic [HEIGHT_W-1:0]     h_in;
   assign hv = (NOISE_W+1)'(res15_ff) + (NOISE_W+1)'(ONE_Q16);
   assign hp = {hv[NOISE_W-1:0], 8'b0} - 27'(hv[NOISE_W-1:0]);

   always_comb begin
      if (hv <= 0) h_in = '0;
      else if (hp[26:FRAC_W+1] > 10'(HEIGHT_MAX)) h_in = HEIGHT_W'(HEIGHT_MAX);
      else h_in = hp[FRAC_W+1 +: HEIGHT_W];
   end

   logic signed [NOISE_W-1:0] noise_ff;
   logic [HEIGHT_W-1:0]       height_ff;
   logic                      ev_ff;
   always_ff @(posedge clock) begin
      if (stage_en[ST_OUT]) begin
         noise_ff  <= ev15_ff ? res15_ff : '0;
         height_ff <= ev15_ff ? h_in : '0;
         ev_ff     <= ev15_ff;
      end
   end

   assign noise_value = noise_ff;
   assign height_byte = height_ff;
   assign is_eval_out = ev_ff;
endmodule
`default_nettype wire

// ===== hdl/fractal_gradient_noise_2d.sv =====
// top level: fractal 2d gradient noise with a loadable permutation table
//
//  channel | direction | handshake              | contents
//  req     | in        | req_tvalid/req_tready  | load or evaluate transaction
//  rsp     | out       | rsp_tvalid/rsp_tready  | one result per request
//  csr     | in        | csr_valid/csr_ready    | octave count
//
// 16 stage pipeline, one transaction per cycle while rsp_tready does not hold results back.
// every octave has its own lane with three copies of the table so that the two
// lookups of stage a and the four of stage b need no arbitration; loads write each copy
// in the stage that reads it, so transactions see the table in order.
// reset clears the valid bits and sets the octave count to 4; table is not cleared.
// each stage moves when the next one is empty or moving, bubbles close up on a stall.
`default_nettype none
module fractal_gradient_noise_2d (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // table_index, table_value, x_coord, y_coord
   input  logic [fgn_pkg::REQ_DATA_W-1:0]     req_tdata,
   // op
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // noise_value, height_byte, zero padding
   output logic [fgn_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // is_eval
   output logic                               rsp_tuser,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [fgn_pkg::OCT_W-1:0]          csr_data
);
   import fgn_pkg::*;

   logic [OCT_W-1:0]          oct_cfg_ff;
   logic [NUM_STAGES:ST_IN]   v_ff;
   logic [NUM_STAGES:ST_IN]   stage_en;

   logic [TBL_AW-1:0]  idx1_ff, idx2_ff;
   logic [BYTE_W-1:0]  val1_ff, val2_ff;
   logic [COORD_W-1:0] x1_ff, y1_ff;
   logic               ev_ff  [ST_IN:ST_NOISE];
   logic [OCT_W-1:0]   oct_ff [ST_IN:ST_NOISE];

   tbl_wr_type wr_a, wr_b;
   logic signed [OCT_NOISE_W-1:0] oct_noise [MAX_OCTAVES];
   logic signed [NOISE_W-1:0]     noise_value;
   logic [HEIGHT_W-1:0]           height_byte;
   logic                          is_eval;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         oct_cfg_ff <= OCT_W'(4);
      end else if (csr_valid) begin
         oct_cfg_ff <= csr_data;
      end
   end

   always_comb begin
      stage_en[NUM_STAGES] = !v_ff[NUM_STAGES] || rsp_tready;
      for (int s = NUM_STAGES - 1; s >= ST_IN; s--) stage_en[s] = !v_ff[s] || stage_en[s+1];
   end

   assign req_tready = stage_en[ST_IN];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (stage_en[ST_IN]) v_ff[ST_IN] <= req_tvalid;
         for (int s = ST_IN + 1; s <= NUM_STAGES; s++) begin
            if (stage_en[s]) v_ff[s] <= v_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_IN]) begin
         idx1_ff       <= req_tdata[TBL_AW-1:0];
         val1_ff       <= req_tdata[8 +: BYTE_W];
         x1_ff         <= req_tdata[16 +: COORD_W];
         y1_ff         <= req_tdata[40 +: COORD_W];
         ev_ff[ST_IN]  <= (req_tuser == OP_EVAL);
         oct_ff[ST_IN] <= clamp_oct(oct_cfg_ff);
      end
      if (stage_en[ST_A]) begin
         idx2_ff <= idx1_ff;
         val2_ff <= val1_ff;
      end
      for (int s = ST_IN + 1; s <= ST_NOISE; s++) begin
         if (stage_en[s]) begin
            ev_ff[s]  <= ev_ff[s-1];
            oct_ff[s] <= oct_ff[s-1];
         end
      end
   end

   // load transactions write each table copy as they pass its read stage
   assign wr_a.we   = v_ff[ST_IN] && !ev_ff[ST_IN] && stage_en[ST_A];
   assign wr_a.addr = idx1_ff;
   assign wr_a.data = val1_ff;
   assign wr_b.we   = v_ff[ST_A] && !ev_ff[ST_A] && stage_en[ST_B];
   assign wr_b.addr = idx2_ff;
   assign wr_b.data = val2_ff;

   for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_lane
      fgn_lane #(.OCT(k)) u_lane (
         .clock    (clock),
         .stage_en (stage_en[LANE_LAST:LANE_FIRST]),
         .wr_a     (wr_a),
         .wr_b     (wr_b),
         .x_coord  (x1_ff),
         .y_coord  (y1_ff),
         .noise    (oct_noise[k])
      );
   end

   fgn_norm u_norm (
      .clock       (clock),
      .stage_en    (stage_en[NUM_STAGES:NORM_FIRST]),
      .oct_noise   (oct_noise),
      .oct_count   (oct_ff[ST_NOISE]),
      .is_eval     (ev_ff[ST_NOISE]),
      .noise_value (noise_value),
      .height_byte (height_byte),
      .is_eval_out (is_eval)
   );

   assign rsp_tvalid = v_ff[NUM_STAGES];
   assign rsp_tdata  = {(RSP_DATA_W - NOISE_W - HEIGHT_W)'(0), height_byte, noise_value};
   assign rsp_tuser  = is_eval;
endmodule
`default_nettype wire

// ===== hdl/fgn_checker.sv =====
// port checker for the noise block and its bind to the top level
`default_nettype none
module fgn_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [fgn_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tuser
);
   import fgn_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_load_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("load acknowledge carries data");

   a_height_low: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser && rsp_tdata[17:16] == 2'b10 |-> rsp_tdata[25:18] == 8'd0)
      else $error("height not zero for noise at or below minus one");

   a_height_high: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser && rsp_tdata[17:16] == 2'b01 |-> rsp_tdata[25:18] == 8'd255)
      else $error("height not full scale for noise at or above one");

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");
endmodule

bind fractal_gradient_noise_2d fgn_checker u_fgn_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

// ===== verif/noise_checker.sv =====
// checker: watches the request, result and csr channels, predicts noise results and compares
module noise_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [fgn_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                          req_tuser,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [fgn_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                          rsp_tuser,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [fgn_pkg::OCT_W-1:0]     csr_data,
   output int                            fail_count,
   output int                            pending
);
   import fgn_pkg::*;

   typedef struct packed {
      logic signed [NOISE_W-1:0] noise;
      logic [HEIGHT_W-1:0]       height;
      logic                      is_eval;
   } noise_result_t;

   logic [7:0]       perm_copy [256];
   logic [OCT_W-1:0] octaves_set;
   noise_result_t    expected_results [$];

   function automatic longint floor_q16(longint v);
      return v >>> 16;
   endfunction

   function automatic longint fade(longint t);
      longint t2, t3, inner;
      t2 = (t * t) >> 16;
      t3 = (t2 * t) >> 16;
      inner = 6 * t2 - 15 * t + 10 * 65536;
      if (inner < 0) inner = 0;
      return (t3 * inner) >> 16;
   endfunction

   function automatic longint gradient(logic [7:0] h, longint gx, longint gy);
      case (h[1:0])
         GRAD_XPY: return gx + gy;
         GRAD_YMX: return gy - gx;
         GRAD_XMY: return gx - gy;
         default:  return -gx - gy;
      endcase
   endfunction

   function automatic longint octave_noise(longint cx, longint cy);
      logic [7:0] ix, iy, ha, hb;
      longint fx, fy, u, v, l1, l2, gaa, gba, gab, gbb;
      ix = 8'(cx >> 16);
      iy = 8'(cy >> 16);
      fx = cx & 64'hFFFF;
      fy = cy & 64'hFFFF;
      u = fade(fx);
      v = fade(fy);
      ha = perm_copy[ix] + iy;
      hb = perm_copy[8'(ix + 8'd1)] + iy;
      gaa = gradient(perm_copy[ha], fx, fy);
      gab = gradient(perm_copy[8'(ha + 8'd1)], fx, fy - 65536);
      gba = gradient(perm_copy[hb], fx - 65536, fy);
      gbb = gradient(perm_copy[8'(hb + 8'd1)], fx - 65536, fy - 65536);
      l1 = gaa + floor_q16(u * (gba - gaa));
      l2 = gab + floor_q16(u * (gbb - gab));
      return l1 + floor_q16(v * (l2 - l1));
   endfunction

   function automatic noise_result_t predict_noise(logic [23:0] x, logic [23:0] y);
      noise_result_t r;
      int n;
      longint acc, total, q, h;
      n = octaves_set;
      if (n < 1) n = 1;
      if (n > MAX_OCTAVES) n = MAX_OCTAVES;
      acc = 0;
      for (int k = 0; k < n; k++)
         acc += octave_noise(longint'(x) << k, longint'(y) << k) * (longint'(1) << (n - 1 - k));
      total = (longint'(1) << n) - 1;
      q = (acc >= 0) ? acc / total : -((-acc + total - 1) / total);
      if (q > NOISE_MAX) q = NOISE_MAX;
      if (q < -NOISE_MIN_MAG) q = -NOISE_MIN_MAG;
      h = q + 65536;
      h = (h <= 0) ? 0 : (h * 255) >> 17;
      if (h > 255) h = 255;
      r.noise = NOISE_W'(q);
      r.height = HEIGHT_W'(h);
      r.is_eval = 1'b1;
      return r;
   endfunction

   always @(posedge clock) begin
      noise_result_t got, want;
      int errs;
      errs = 0;
      if (reset) begin
         octaves_set <= OCT_W'(4);
         fail_count <= 0;
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready) octaves_set <= csr_data;
         if (req_tvalid && req_tready) begin
            if (req_tuser == OP_LOAD) begin
               perm_copy[req_tdata[7:0]] = req_tdata[15:8];
               expected_results.push_back('0);
            end else begin
               expected_results.push_back(predict_noise(req_tdata[39:16], req_tdata[63:40]));
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got.noise = rsp_tdata[17:0];
            got.height = rsp_tdata[25:18];
            got.is_eval = rsp_tuser;
            if (expected_results.size() == 0) begin
               $error("result with nothing expected: %h", rsp_tdata);
               errs = errs + 1;
            end else begin
               want = expected_results.pop_front();
               if (got.noise !== want.noise) begin
                  $error("noise_value expected %0d actual %0d", want.noise, got.noise);
                  errs = errs + 1;
               end
               if (got.height !== want.height) begin
                  $error("height_byte expected %0d actual %0d", want.height, got.height);
                  errs = errs + 1;
               end
               if (got.is_eval !== want.is_eval) begin
                  $error("is_eval expected %0d actual %0d", want.is_eval, got.is_eval);
                  errs = errs + 1;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
      pending = expected_results.size();
   end
endmodule

// ===== verif/testbench.sv =====
// testbench top: drives table loads, noise evaluations and octave settings, gives the verdict
module testbench;
   import fgn_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0, req_tready, req_tuser = 0;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid, rsp_tready = 0, rsp_tuser;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_valid = 0, csr_ready;
   logic [OCT_W-1:0] csr_data = '0;
   int fail_count, pending;
   int send_idle_pct = 0, recv_idle_pct = 0;
   bit recv_hold = 0;

   always #5 clock = ~clock;

   fractal_gradient_noise_2d i_dut (.*);

   noise_checker i_checker (.*);

   // receiver readiness, with a long hold-off when asked
   always @(posedge clock) begin
      if (reset) rsp_tready <= 0;
      else rsp_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send(logic op, logic [REQ_DATA_W-1:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= op;
      req_tdata <= data;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic load_entry(logic [7:0] idx, logic [7:0] val);
      send(OP_LOAD, {48'd0, val, idx});
   endtask

   task automatic evaluate(logic [23:0] x, logic [23:0] y);
      send(OP_EVAL, {y, x, 16'd0});
   endtask

   // pending is sampled away from the rising edge so the last transaction is counted
   task automatic drain;
      req_tvalid <= 0;
      do @(negedge clock); while (pending != 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_octaves(logic [OCT_W-1:0] n);
      drain();
      csr_valid <= 1;
      csr_data <= n;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
   endtask

   task automatic random_eval;
      logic [23:0] x, y;
      x = 24'($urandom);
      y = 24'($urandom);
      if ($urandom_range(3) == 0) x[15:0] = $urandom_range(1) ? 16'h0000 : 16'hFFFF;
      evaluate(x, y);
   endtask

   initial begin
      #2_000_000;
      $display("testbench: FAIL");
      $finish;
   end

   initial begin
      logic [OCT_W-1:0] oct_seq [6] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd5};
      repeat (11) @(posedge clock);
      reset <= 0;
      // fill the whole table before any evaluation reads it
      for (int i = 0; i < 256; i++) load_entry(8'(i), 8'($urandom));
      // directed: extremes of coordinates and overwrite of the wrap entry
      set_octaves(4'd1);
      evaluate(24'h000000, 24'h000000);
      evaluate(24'hFFFFFF, 24'hFFFFFF);
      evaluate(24'hFF0000, 24'h00FFFF);
      evaluate(24'h008000, 24'h008000);
      load_entry(8'd0, 8'hFF);
      load_entry(8'd255, 8'h00);
      evaluate(24'hFFFFFF, 24'h000001);
      set_octaves(4'd8);
      evaluate(24'hFFFFFF, 24'hFFFFFF);
      evaluate(24'h7FFFFF, 24'h800000);
      evaluate(24'h000000, 24'hFFFFFF);
      set_octaves(4'd0);
      evaluate(24'h123456, 24'hABCDEF);
      set_octaves(4'd15);
      evaluate(24'h0000FF, 24'hFF00FF);
      // random phases
      for (int ph = 0; ph < 6; ph++) begin
         set_octaves(oct_seq[ph]);
         send_idle_pct = (ph < 2) ? 21 : (ph < 4) ? 62 : 0;
         recv_idle_pct = (ph < 2) ? 62 : (ph < 4) ? 21 : 0;
         if (ph == 4) begin
            recv_hold = 1;
            fork
               begin
                  repeat (60) @(posedge clock);
                  recv_hold = 0;
               end
            join_none
         end
         for (int i = 0; i < 220; i++) begin
            if ($urandom_range(9) == 0) load_entry(8'($urandom), 8'($urandom));
            else random_eval();
         end
         if (ph == 3) drain();
      end
      drain();
      if (fail_count == 0) $display("testbench: PASS");
      else $display("testbench: FAIL");
      $finish;
   end
endmodule

// ===== files.f =====
hdl/fgn_pkg.sv
hdl/fgn_lane.sv
hdl/fgn_norm.sv
hdl/fractal_gradient_noise_2d.sv
hdl/fgn_checker.sv
verif/noise_checker.sv
verif/testbench.sv
